/* rtl/smhc_pkg.sv */
package smhc_pkg;

    // Input mode codes
    localparam logic [2:0] MODE_TICK = 3'd0;
    localparam logic [2:0] MODE_HOME = 3'd1;
    localparam logic [2:0] MODE_UP   = 3'd2;
    localparam logic [2:0] MODE_DOWN = 3'd3;
    localparam logic [2:0] MODE_STOP = 3'd4;

    // Configuration register indexes
    localparam logic CFG_HOME_RATE = 1'b0;
    localparam logic CFG_MOVE_RATE = 1'b1;

    // Rate register reset values
    localparam logic [16:0] HOME_RATE_RST = 17'd1000;
    localparam logic [16:0] MOVE_RATE_RST = 17'd4000;

    // Limit switch sampling: one sample every POLL_DIVIDER ticks, homing ends
    // once the run of active samples exceeds DEBOUNCE_LIMIT
    localparam logic [4:0]  POLL_DIVIDER   = 5'd20;
    localparam logic [3:0]  DEBOUNCE_LIMIT = 4'd10;
    localparam logic [3:0]  DEBOUNCE_MAX   = 4'hF;
    localparam logic [15:0] HOME_STEPS     = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] steps;
        logic        limit_hit;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic        motor_enable;
        logic        direction;
        logic        timer_on;
        logic [16:0] step_rate_hz;
        logic        is_moving;
        logic        is_homing;
        logic        is_homed;
        logic [15:0] steps_remaining;
    } t_out_item;

endpackage

/* rtl/smhc_core.sv */
module smhc_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  smhc_pkg::t_in_item   i_item,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [16:0]          i_cfg_data,
    output smhc_pkg::t_out_item  o_result
);

    // Rate registers
    logic [16:0] r_home_rate;
    logic [16:0] r_move_rate;

    // Controller state
    logic        r_moving;
    logic        r_homing;
    logic        r_homed;
    logic [15:0] r_step_count;
    logic [4:0]  r_poll_count;
    logic [3:0]  r_debounce;
    logic        r_dir;
    logic        r_enable;
    logic        r_clock_on;
    logic        r_rate_home;

    logic        n_moving;
    logic        n_homing;
    logic        n_homed;
    logic [15:0] n_step_count;
    logic [4:0]  n_poll_count;
    logic [3:0]  n_debounce;
    logic        n_dir;
    logic        n_enable;
    logic        n_clock_on;
    logic        n_rate_home;

    logic        accepted;
    logic [4:0]  poll_inc;
    logic [3:0]  debounce_inc;
    logic [15:0] step_dec;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home_rate <= smhc_pkg::HOME_RATE_RST;
            r_move_rate <= smhc_pkg::MOVE_RATE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == smhc_pkg::CFG_HOME_RATE) begin
                r_home_rate <= i_cfg_data;
            end else begin
                r_move_rate <= i_cfg_data;
            end
        end
    end

    // Next state for one transaction
    always_comb begin
        n_moving     = r_moving;
        n_homing     = r_homing;
        n_homed      = r_homed;
        n_step_count = r_step_count;
        n_poll_count = r_poll_count;
        n_debounce   = r_debounce;
        n_dir        = r_dir;
        n_enable     = r_enable;
        n_clock_on   = r_clock_on;
        n_rate_home  = r_rate_home;
        accepted     = 1'b0;

        poll_inc     = r_poll_count + 5'd1;
        debounce_inc = (r_debounce != smhc_pkg::DEBOUNCE_MAX) ? r_debounce + 4'd1 : r_debounce;
        step_dec     = (r_step_count != 16'd0) ? r_step_count - 16'd1 : r_step_count;

        case (i_item.mode)
            smhc_pkg::MODE_TICK: begin
                if (r_clock_on) begin
                    accepted = 1'b1;
                    if (r_homing) begin
                        // sample the limit switch every POLL_DIVIDER ticks
                        n_poll_count = poll_inc;
                        if (poll_inc >= smhc_pkg::POLL_DIVIDER) begin
                            n_poll_count = 5'd0;
                            if (i_item.limit_hit) begin
                                n_debounce = debounce_inc;
                                if (debounce_inc > smhc_pkg::DEBOUNCE_LIMIT) begin
                                    n_homing     = 1'b0;
                                    n_moving     = 1'b0;
                                    n_homed      = 1'b1;
                                    n_step_count = 16'd0;
                                    n_clock_on   = 1'b0;
                                    n_enable     = 1'b0;
                                end
                            end else begin
                                n_debounce = 4'd0;
                            end
                        end
                    end else if (r_moving) begin
                        n_step_count = step_dec;
                        if (step_dec == 16'd0) begin
                            n_moving   = 1'b0;
                            n_clock_on = 1'b0;
                            n_enable   = 1'b0;
                        end
                    end
                end
            end
            smhc_pkg::MODE_HOME: begin
                // rejected during an up/down move, restarts during homing
                if (!(r_moving && !r_homing)) begin
                    accepted     = 1'b1;
                    n_homing     = 1'b1;
                    n_homed      = 1'b0;
                    n_moving     = 1'b1;
                    n_debounce   = 4'd0;
                    n_poll_count = 5'd0;
                    n_dir        = 1'b0;
                    n_enable     = 1'b1;
                    n_step_count = smhc_pkg::HOME_STEPS;
                    if (r_home_rate != 17'd0) begin
                        n_clock_on  = 1'b1;
                        n_rate_home = 1'b1;
                    end
                end
            end
            smhc_pkg::MODE_UP, smhc_pkg::MODE_DOWN: begin
                if (!r_moving) begin
                    accepted     = 1'b1;
                    n_dir        = (i_item.mode == smhc_pkg::MODE_UP);
                    n_enable     = 1'b1;
                    n_step_count = i_item.steps;
                    n_moving     = 1'b1;
                    n_homing     = 1'b0;
                    if (r_move_rate != 17'd0) begin
                        n_poll_count = 5'd0;
                        n_clock_on   = 1'b1;
                        n_rate_home  = 1'b0;
                    end
                end
            end
            smhc_pkg::MODE_STOP: begin
                if (r_moving || r_homing) begin
                    accepted     = 1'b1;
                    n_moving     = 1'b0;
                    n_homing     = 1'b0;
                    n_step_count = 16'd0;
                    n_clock_on   = 1'b0;
                    n_enable     = 1'b0;
                end
            end
            default: begin
                accepted = 1'b0;
            end
        endcase
    end

    // Result reflects the state after this transaction
    always_comb begin
        o_result.accepted        = accepted;
        o_result.motor_enable    = n_enable;
        o_result.direction       = n_dir;
        o_result.timer_on        = n_clock_on;
        o_result.step_rate_hz    = n_clock_on ? (n_rate_home ? r_home_rate : r_move_rate)
                                              : 17'd0;
        o_result.is_moving       = n_moving;
        o_result.is_homing       = n_homing;
        o_result.is_homed        = n_homed;
        o_result.steps_remaining = n_step_count;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_moving     <= 1'b0;
            r_homing     <= 1'b0;
            r_homed      <= 1'b0;
            r_step_count <= 16'd0;
            r_poll_count <= 5'd0;
            r_debounce   <= 4'd0;
            r_dir        <= 1'b0;
            r_enable     <= 1'b0;
            r_clock_on   <= 1'b0;
            r_rate_home  <= 1'b0;
        end else if (i_fire) begin
            r_moving     <= n_moving;
            r_homing     <= n_homing;
            r_homed      <= n_homed;
            r_step_count <= n_step_count;
            r_poll_count <= n_poll_count;
            r_debounce   <= n_debounce;
            r_dir        <= n_dir;
            r_enable     <= n_enable;
            r_clock_on   <= n_clock_on;
            r_rate_home  <= n_rate_home;
        end
    end

endmodule

/* rtl/stepper_move_and_home_controller.sv */
// Channel  | Signals                               | Direction
// ---------+---------------------------------------+----------
// input    | i_in_valid, o_in_stall, i_in_item     | in
// result   | o_out_valid, i_out_stall, o_out_item  | out
// config   | i_cfg_we, i_cfg_index, i_cfg_data     | in
//
// One transaction per cycle while the result side does not stall. A command or tick is
// held in the input register, processed against the controller state and then
// registered in the result register, from which its result is offered; it moves on
// once the result register is free or being drained.
// Reset (i_rst_n low, synchronous) clears both pipeline stages and the state
// and loads the rate registers with 1000 and 4000. A stall on the result side
// stops the pipeline; the input register and result register absorb it.
module stepper_move_and_home_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  smhc_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output smhc_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [16:0]          i_cfg_data
);

    logic                r_in_valid;
    smhc_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    smhc_pkg::t_out_item r_out_item;
    smhc_pkg::t_out_item result;
    logic                advance;

    // Pipeline moves when the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
    end

    smhc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_item      (r_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* tb/sv/tb_stepper_move_and_home_controller.sv */
`timescale 1ns / 1ps

module tb_stepper_move_and_home_controller;

    // Mode codes that the controller ignores
    localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] MODE_UNUSED_MID   = 3'd6;
    localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

    localparam int unsigned NUM_PHASES     = 6;
    localparam int unsigned PHASE_ITEMS    = 190;
    localparam int unsigned LONG_HOLD      = 40;
    localparam int unsigned WATCHDOG_LIMIT = 500;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam logic [16:0] RATE_MAX       = 17'd100000;

    // Status predictor plus queue of expected status transactions
    class motion_scoreboard;
        logic [16:0] home_rate = smhc_pkg::HOME_RATE_RST;
        logic [16:0] move_rate = smhc_pkg::MOVE_RATE_RST;
        logic        moving    = 1'b0;
        logic        homing    = 1'b0;
        logic        homed     = 1'b0;
        logic        dir_up    = 1'b0;
        logic        drv_en    = 1'b0;
        logic        clk_run   = 1'b0;
        logic        rate_home = 1'b0;
        logic [15:0] step_cnt  = '0;
        logic [4:0]  poll_cnt  = '0;
        logic [3:0]  deb_cnt   = '0;
        smhc_pkg::t_out_item expected_status[$];
        int unsigned errors       = 0;
        int unsigned n_cmds       = 0;
        int unsigned n_results    = 0;
        int unsigned n_homed      = 0;
        int unsigned n_moves_done = 0;
        int unsigned n_rejected   = 0;

        function void set_rate(logic idx, logic [16:0] val);
            if (idx == smhc_pkg::CFG_HOME_RATE) begin
                home_rate = val;
            end else begin
                move_rate = val;
            end
        endfunction

        // a zero rate leaves the step clock as it was
        function void start_clock(logic from_home);
            if ((from_home ? home_rate : move_rate) != '0) begin
                poll_cnt  = '0;
                clk_run   = 1'b1;
                rate_home = from_home;
            end
        endfunction

        function void stop_clock();
            clk_run = 1'b0;
            drv_en  = 1'b0;
        endfunction

        // Apply one command or tick and queue the status it should produce
        function void note_command(smhc_pkg::t_in_item cmd);
            logic                ok;
            smhc_pkg::t_out_item st;
            ok = 1'b0;
            case (cmd.mode)
                smhc_pkg::MODE_TICK: begin
                    if (clk_run) begin
                        ok = 1'b1;
                        if (homing) begin
                            // limit switch is only looked at on every Nth tick
                            poll_cnt = poll_cnt + 5'd1;
                            if (poll_cnt >= smhc_pkg::POLL_DIVIDER) begin
                                poll_cnt = '0;
                                if (cmd.limit_hit) begin
                                    if (deb_cnt < smhc_pkg::DEBOUNCE_MAX)
                                        deb_cnt++;
                                    if (deb_cnt > smhc_pkg::DEBOUNCE_LIMIT) begin
                                        homing   = 1'b0;
                                        moving   = 1'b0;
                                        homed    = 1'b1;
                                        step_cnt = '0;
                                        stop_clock();
                                        n_homed++;
                                    end
                                end else begin
                                    deb_cnt = '0;
                                end
                            end
                        end else if (moving) begin
                            if (step_cnt != '0)
                                step_cnt--;
                            if (step_cnt == '0) begin
                                moving = 1'b0;
                                stop_clock();
                                n_moves_done++;
                            end
                        end
                    end
                end
                smhc_pkg::MODE_HOME: begin
                    // refused during a plain move, restarts an ongoing homing
                    if (!(moving && !homing)) begin
                        ok       = 1'b1;
                        homing   = 1'b1;
                        homed    = 1'b0;
                        moving   = 1'b1;
                        deb_cnt  = '0;
                        poll_cnt = '0;
                        dir_up   = 1'b0;
                        drv_en   = 1'b1;
                        step_cnt = smhc_pkg::HOME_STEPS;
                        start_clock(1'b1);
                    end
                end
                smhc_pkg::MODE_UP, smhc_pkg::MODE_DOWN: begin
                    if (!moving) begin
                        ok       = 1'b1;
                        dir_up   = (cmd.mode == smhc_pkg::MODE_UP);
                        drv_en   = 1'b1;
                        step_cnt = cmd.steps;
                        moving   = 1'b1;
                        homing   = 1'b0;
                        start_clock(1'b0);
                    end
                end
                smhc_pkg::MODE_STOP: begin
                    if (moving || homing) begin
                        ok       = 1'b1;
                        moving   = 1'b0;
                        homing   = 1'b0;
                        step_cnt = '0;
                        stop_clock();
                    end
                end
                default: begin
                end
            endcase

            st.accepted        = ok;
            st.motor_enable    = drv_en;
            st.direction       = dir_up;
            st.timer_on        = clk_run;
            st.step_rate_hz    = clk_run ? (rate_home ? home_rate : move_rate) : '0;
            st.is_moving       = moving;
            st.is_homing       = homing;
            st.is_homed        = homed;
            st.steps_remaining = step_cnt;
            expected_status.push_back(st);
            n_cmds++;
            if (!ok)
                n_rejected++;
        endfunction

        // Compare one status transaction against the oldest expectation
        function void check_status(smhc_pkg::t_out_item got);
            smhc_pkg::t_out_item want;
            string               bad;
            n_results++;
            if (expected_status.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: unexpected status %h at %0t", got, $realtime);
            end else begin
                want = expected_status.pop_front();
                bad  = "";
                if (got.accepted !== want.accepted)               bad = {bad, " accepted"};
                if (got.motor_enable !== want.motor_enable)       bad = {bad, " motor_enable"};
                if (got.direction !== want.direction)             bad = {bad, " direction"};
                if (got.timer_on !== want.timer_on)               bad = {bad, " timer_on"};
                if (got.step_rate_hz !== want.step_rate_hz)       bad = {bad, " step_rate_hz"};
                if (got.is_moving !== want.is_moving)             bad = {bad, " is_moving"};
                if (got.is_homing !== want.is_homing)             bad = {bad, " is_homing"};
                if (got.is_homed !== want.is_homed)               bad = {bad, " is_homed"};
                if (got.steps_remaining !== want.steps_remaining) bad = {bad, " steps_remaining"};
                if (bad != "") begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("ERROR: status #%0d at %0t differs in%s: expected %h, got %h",
                                 n_results, $realtime, bad, want, got);
                end
            end
        endfunction
    endclass

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    smhc_pkg::t_in_item  in_item   = '0;
    logic                out_stall = 1'b0;
    logic                cfg_we    = 1'b0;
    logic                cfg_index = smhc_pkg::CFG_HOME_RATE;
    logic [16:0]         cfg_data  = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    smhc_pkg::t_out_item o_out_item;

    motion_scoreboard sb;
    int unsigned sent_count  = 0;
    int unsigned idle_cycles = 0;
    int unsigned tx_quiet    = 0;
    int unsigned n_holds     = 0;
    logic        tx_gaps     = 1'b1;
    logic        rx_gaps     = 1'b1;
    logic        hold_req    = 1'b0;

    stepper_move_and_home_controller uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Monitor both channels; an input is noted before any status is checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !o_in_stall)
                sb.note_command(in_item);
            if (o_out_valid && !out_stall)
                sb.check_status(o_out_item);
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Watchdog on cycles without any transaction
    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: random stall bursts, quiet stretches, one long hold-off on request
    initial begin : rx_stall_gen
        int unsigned rx_quiet;
        rx_quiet = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                out_stall = 1'b0;
                hold_req  = 1'b0;
                n_holds++;
            end else if (!rx_gaps) begin
                out_stall = 1'b0;
            end else if (rx_quiet != 0) begin
                rx_quiet--;
            end else if ($urandom_range(0, 15) == 0) begin
                rx_quiet = $urandom_range(10, 40);
            end else if ($urandom_range(0, 3) == 0) begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                out_stall = 1'b0;
            end
        end
    end

    // Offer one transaction and hold it until taken; may leave a gap after it
    task automatic send_cmd(input logic [2:0] mode, input logic [15:0] steps,
                            input logic lim);
        in_item.mode      = mode;
        in_item.steps     = steps;
        in_item.limit_hit = lim;
        in_valid          = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        sent_count++;
        if (tx_gaps) begin
            if (tx_quiet != 0) begin
                tx_quiet--;
            end else if ($urandom_range(0, 15) == 0) begin
                tx_quiet = $urandom_range(10, 40);
            end else if ($urandom_range(0, 4) == 0) begin
                in_valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
    endtask

    // Tick with a limit level; now and then an arbitrary command breaks the sequence
    task automatic send_tick(input logic solid);
        if ($urandom_range(0, 24) == 0)
            send_cmd(3'($urandom_range(smhc_pkg::MODE_TICK, MODE_UNUSED_LAST)),
                     16'($urandom), 1'($urandom));
        else
            send_cmd(smhc_pkg::MODE_TICK, 16'($urandom),
                     solid ? logic'($urandom_range(0, 80) != 0) : logic'($urandom_range(0, 1)));
    endtask

    // Stop offering and wait for every expected status
    task automatic wait_drain();
        in_valid = 1'b0;
        while (sb.expected_status.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_rate(input logic idx, input logic [16:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge i_clk);
        cfg_we    = 1'b0;
        sb.set_rate(idx, val);
    endtask

    // Mostly homing runs and short moves with random content, some noise
    task automatic run_traffic(input int unsigned target);
        int unsigned stop_at;
        int unsigned n;
        int unsigned k;
        int unsigned pick;
        logic [15:0] cnt;
        stop_at = sent_count + target;
        while (sent_count < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // long enough to debounce about half of the time
                n = ($urandom_range(0, 1) != 0) ? $urandom_range(225, 260)
                                                : $urandom_range(5, 60);
                send_cmd(smhc_pkg::MODE_HOME, 16'($urandom), 1'($urandom));
                for (k = 0; k < n; k++)
                    send_tick(k + 225 >= n);
                if ($urandom_range(0, 1) != 0)
                    send_cmd(smhc_pkg::MODE_STOP, 16'($urandom), 1'($urandom));
            end else if (pick < 90) begin
                cnt = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
                send_cmd(($urandom_range(0, 1) != 0) ? smhc_pkg::MODE_UP : smhc_pkg::MODE_DOWN,
                         cnt, 1'($urandom));
                n = (cnt < 40) ? cnt + $urandom_range(0, 3) : $urandom_range(5, 40);
                for (k = 0; k < n; k++)
                    send_tick(1'b0);
                if ($urandom_range(0, 2) == 0)
                    send_cmd(smhc_pkg::MODE_STOP, 16'($urandom), 1'($urandom));
            end else begin
                send_cmd(3'($urandom_range(smhc_pkg::MODE_TICK, MODE_UNUSED_LAST)),
                         16'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin : main_seq
        int unsigned ph;
        logic [16:0] home_val;
        logic [16:0] move_val;
        sb = new();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: idle commands, rejections, zero and full step counts, homing restart
        send_cmd(smhc_pkg::MODE_TICK, 16'h0000, 1'b1);
        send_cmd(smhc_pkg::MODE_STOP, 16'h0000, 1'b0);
        send_cmd(MODE_UNUSED_FIRST, 16'h0000, 1'b0);
        send_cmd(MODE_UNUSED_LAST, 16'hFFFF, 1'b1);
        send_cmd(smhc_pkg::MODE_UP, 16'hFFFF, 1'b0);
        send_cmd(smhc_pkg::MODE_UP, 16'h0005, 1'b0);
        send_cmd(smhc_pkg::MODE_HOME, 16'h0000, 1'b0);
        send_cmd(smhc_pkg::MODE_TICK, 16'hFFFF, 1'b0);
        send_cmd(smhc_pkg::MODE_STOP, 16'hFFFF, 1'b1);
        send_cmd(smhc_pkg::MODE_TICK, 16'h0000, 1'b0);
        send_cmd(smhc_pkg::MODE_DOWN, 16'h0000, 1'b0);
        send_cmd(smhc_pkg::MODE_TICK, 16'h0000, 1'b1);
        send_cmd(smhc_pkg::MODE_DOWN, 16'h0001, 1'b1);
        send_cmd(smhc_pkg::MODE_TICK, 16'hFFFF, 1'b1);
        send_cmd(smhc_pkg::MODE_TICK, 16'h0000, 1'b0);
        send_cmd(smhc_pkg::MODE_HOME, 16'hFFFF, 1'b1);
        send_cmd(smhc_pkg::MODE_TICK, 16'h0000, 1'b1);
        send_cmd(smhc_pkg::MODE_HOME, 16'h0000, 1'b0);
        send_cmd(smhc_pkg::MODE_DOWN, 16'h0003, 1'b0);
        send_cmd(smhc_pkg::MODE_STOP, 16'h0000, 1'b0);
        send_cmd(MODE_UNUSED_MID, 16'h5555, 1'b0);
        send_cmd(smhc_pkg::MODE_STOP, 16'hAAAA, 1'b1);
        send_cmd(smhc_pkg::MODE_UP, 16'h0002, 1'b1);
        send_cmd(smhc_pkg::MODE_TICK, 16'h0000, 1'b0);
        send_cmd(smhc_pkg::MODE_TICK, 16'h0000, 1'b0);
        wait_drain();

        // Random phases under different rate settings; motion may span a change
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    home_val = '0;
                    move_val = '0;
                end
                1: begin
                    home_val = RATE_MAX;
                    move_val = RATE_MAX;
                end
                2: begin
                    home_val = 17'd1;
                    move_val = '0;
                end
                3: begin
                    home_val = '0;
                    move_val = 17'd1;
                end
                default: begin
                    home_val = 17'($urandom_range(0, RATE_MAX));
                    move_val = 17'($urandom_range(0, RATE_MAX));
                end
            endcase
            write_rate(smhc_pkg::CFG_HOME_RATE, home_val);
            write_rate(smhc_pkg::CFG_MOVE_RATE, move_val);
            if (ph == NUM_PHASES - 1) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            if (ph == 1 || ph == 3)
                hold_req = 1'b1;
            run_traffic(PHASE_ITEMS);
            wait_drain();
        end

        repeat (8) @(posedge i_clk);
        if (sb.expected_status.size() != 0) begin
            sb.errors++;
            $display("ERROR: %0d status transactions never arrived", sb.expected_status.size());
        end
        $display("Run covered %0d commands and ticks (%0d refused or ignored), %0d homings",
                 sb.n_cmds, sb.n_rejected, sb.n_homed);
        $display("completed, %0d moves run out, %0d rate settings, %0d long result hold-offs",
                 sb.n_moves_done, NUM_PHASES + 1, n_holds);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches in total", sb.errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
